/* src/brf_pkg.sv */
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types, codes and bank/vector lookup functions for the banked
// register file with exception entry.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int NumPhys = 31;
  localparam int NumSaved = 16;

  // transaction kinds
  localparam logic [2:0] KIND_RAISE  = 3'd0;
  localparam logic [2:0] KIND_CLEAR  = 3'd1;
  localparam logic [2:0] KIND_HANDLE = 3'd2;
  localparam logic [2:0] KIND_READ   = 3'd3;
  localparam logic [2:0] KIND_WRITE  = 3'd4;

  // low four mode bits
  localparam logic [3:0] MODE_USR = 4'h0;
  localparam logic [3:0] MODE_FIQ = 4'h1;
  localparam logic [3:0] MODE_IRQ = 4'h2;
  localparam logic [3:0] MODE_SVC = 4'h3;
  localparam logic [3:0] MODE_ABT = 4'h7;
  localparam logic [3:0] MODE_UND = 4'hB;
  localparam logic [3:0] MODE_SYS = 4'hF;

  localparam logic [3:0] REG_R8 = 4'd8;
  localparam logic [3:0] REG_R12 = 4'd12;
  localparam logic [3:0] REG_SP = 4'd13;
  localparam logic [3:0] REG_LR = 4'd14;
  localparam logic [4:0] SLOT_PC = 5'd15;

  // physical slots of the banked registers
  localparam logic [4:0] SLOT_NONE   = 5'd0;
  localparam logic [4:0] SLOT_FIQ_SP = 5'd16;
  localparam logic [4:0] SLOT_IRQ_SP = 5'd18;
  localparam logic [4:0] SLOT_SVC_SP = 5'd20;
  localparam logic [4:0] SLOT_ABT_SP = 5'd22;
  localparam logic [4:0] SLOT_UND_SP = 5'd24;
  localparam logic [4:0] SLOT_FIQ_R8 = 5'd26;

  // exception bit positions, highest priority first
  localparam logic [2:0] EXC_UNPRED = 3'd0;
  localparam logic [2:0] EXC_RESET  = 3'd1;
  localparam logic [2:0] EXC_UNDEF  = 3'd2;
  localparam logic [2:0] EXC_SWI    = 3'd3;
  localparam logic [2:0] EXC_PABT   = 3'd4;
  localparam logic [2:0] EXC_DABT   = 3'd5;
  localparam logic [2:0] EXC_IRQ    = 3'd6;
  localparam logic [2:0] EXC_FIQ    = 3'd7;

  localparam logic [31:0] PC_OFFSET = 32'd8;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  exc_mask;
    logic [3:0]  bank_mode;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  taken;
    logic [31:0] read_data;
    logic        access_error;
    logic [4:0]  cpsr_mode;
    logic [3:0]  saved_mode;
    logic        irq_disabled;
    logic        fiq_disabled;
    logic        thumb_state;
    logic [7:0]  pending;
    logic        flush;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] slot;
  } slot_t;

  function automatic slot_t bank_slot(logic [3:0] mode, logic [3:0] r);
    slot_t      s;
    logic [4:0] sp_base;
    s.ok = 1'b1;
    s.slot = {1'b0, r};
    sp_base = SLOT_NONE;
    case (mode)
      MODE_USR, MODE_SYS: sp_base = SLOT_NONE;
      MODE_FIQ: sp_base = SLOT_FIQ_SP;
      MODE_IRQ: sp_base = SLOT_IRQ_SP;
      MODE_SVC: sp_base = SLOT_SVC_SP;
      MODE_ABT: sp_base = SLOT_ABT_SP;
      MODE_UND: sp_base = SLOT_UND_SP;
      default:  s.ok = 1'b0;
    endcase
    if (sp_base != SLOT_NONE) begin
      if (r == REG_SP) begin
        s.slot = sp_base;
      end else if (r == REG_LR) begin
        s.slot = sp_base + 5'd1;
      end
    end
    if (mode == MODE_FIQ && r >= REG_R8 && r <= REG_R12) begin
      s.slot = SLOT_FIQ_R8 + ({1'b0, r} - {1'b0, REG_R8});
    end
    return s;
  endfunction

  function automatic logic [3:0] exc_mode(logic [2:0] b);
    logic [3:0] m;
    case (b)
      EXC_UNDEF:          m = MODE_UND;
      EXC_SWI:            m = MODE_SVC;
      EXC_PABT, EXC_DABT: m = MODE_ABT;
      EXC_IRQ:            m = MODE_IRQ;
      EXC_FIQ:            m = MODE_FIQ;
      default:            m = MODE_SVC;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] exc_vector(logic [2:0] b);
    logic [31:0] v;
    case (b)
      EXC_UNDEF: v = 32'h0000_0004;
      EXC_SWI:   v = 32'h0000_0008;
      EXC_PABT:  v = 32'h0000_000C;
      EXC_DABT:  v = 32'h0000_0010;
      EXC_IRQ:   v = 32'h0000_0018;
      EXC_FIQ:   v = 32'h0000_001C;
      default:   v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

/* src/banked_register_file_exception_entry_core.sv */
// ----------------------------------------------------------------------------
// banked_register_file_exception_entry_core
// Banked register file with pending-exception entry, top level.
// ----------------------------------------------------------------------------
// Each accepted transaction is captured in the input register; in the execute
// state that follows, the datapath updates the register banks, status and
// pending bits and loads the output register, and no new transaction is taken
// while one executes. The next transaction is captured only once the
// output register is empty or is being taken at that same edge, so a result
// held by out_stall stalls the input until it leaves. A handle transaction
// picks the lowest set pending bit; an exception entry saves the mode,
// switches bank, writes LR = PC + 8 and loads PC with the vector in that same
// execute cycle. A taken reset clears all 31 physical registers and all saved
// status at once.
module banked_register_file_exception_entry_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  brf_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output brf_pkg::out_item_t out_item
);
  import brf_pkg::*;

  ctrl_cmd_t cmd;

  brf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  brf_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

  // no two transactions in back-to-back cycles
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("transaction accepted while previous one executes");

  // a flush only comes from reset or a real exception entry
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.flush) |-> (out_item.taken >= 4'd2))
    else $error("flush without a taken exception");

  // a bad bank never returns data
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.access_error) |-> (out_item.read_data == 32'd0))
    else $error("read data on access error");

  // processor mode always has bit four set
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.cpsr_mode[4])
    else $error("mode bit four clear");

endmodule

/* src/brf_ctrl.sv */
// ----------------------------------------------------------------------------
// brf_ctrl
// Sequencer: captures a transaction, runs its execute state, and tracks the
// output register.
// ----------------------------------------------------------------------------
module brf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output brf_pkg::ctrl_cmd_t cmd
);
  import brf_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   accept;

  // output register must be free (or draining) before a new transaction starts
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept = in_valid && !in_stall;
  assign cmd.capture = accept;
  assign cmd.exec = (state_r == S_EXEC);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (out_valid_r && !out_stall) begin
            out_valid_r <= 1'b0;
          end
          if (accept) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* src/brf_dp.sv */
// ----------------------------------------------------------------------------
// brf_dp
// Datapath: register banks, status, pending bits, exception priority pick
// and the output register.
// ----------------------------------------------------------------------------
module brf_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  brf_pkg::ctrl_cmd_t cmd,
  input  brf_pkg::in_item_t  in_item,
  output brf_pkg::out_item_t out_item
);
  import brf_pkg::*;

  in_item_t    item_r;
  out_item_t   out_r;
  out_item_t   out_nxt;

  logic [31:0] phys_r [NumPhys];
  logic [3:0]  saved_r [NumSaved];
  logic [3:0]  mode_r, mode_nxt;
  logic        t_r, t_nxt;
  logic        f_r, f_nxt;
  logic        i_r, i_nxt;
  logic [7:0]  pending_r, pending_nxt;

  slot_t       acc;
  slot_t       lr;
  logic [2:0]  pick;
  logic [3:0]  ent_mode;
  logic        is_handle;
  logic        take_any;
  logic        take_reset;
  logic        take_entry;
  logic        clear_all;
  logic        reg_we;
  logic [4:0]  reg_slot;
  logic [31:0] reg_data;
  logic        pc_we;
  logic [31:0] pc_data;
  logic        sv_we;
  logic [3:0]  sv_data;
  logic [3:0]  saved_rd;

  assign acc = bank_slot(item_r.bank_mode, item_r.reg_index);
  assign ent_mode = exc_mode(pick);
  assign lr = bank_slot(ent_mode, REG_LR);

  // lowest set bit has the highest priority
  always_comb begin
    pick = EXC_FIQ;
    for (int i = 7; i >= 0; i--) begin
      if (pending_r[i]) begin
        pick = 3'(i);
      end
    end
  end

  assign is_handle = (item_r.kind == KIND_HANDLE);
  assign take_any = is_handle && (pending_r != 8'd0);
  assign take_reset = take_any && (pick == EXC_RESET);
  assign take_entry = take_any && (pick != EXC_RESET) && (pick != EXC_UNPRED);
  assign clear_all = take_reset;

  always_comb begin
    mode_nxt = mode_r;
    t_nxt = t_r;
    f_nxt = f_r;
    i_nxt = i_r;
    pending_nxt = pending_r;
    reg_we = 1'b0;
    reg_slot = acc.slot;
    reg_data = item_r.write_data;
    pc_we = 1'b0;
    pc_data = exc_vector(pick);
    sv_we = 1'b0;
    sv_data = mode_r;
    case (item_r.kind)
      KIND_RAISE: pending_nxt = pending_r | item_r.exc_mask;
      KIND_CLEAR: pending_nxt = pending_r & ~item_r.exc_mask;
      KIND_HANDLE: begin
        if (take_reset) begin
          mode_nxt = MODE_SVC;
          t_nxt = 1'b0;
          f_nxt = 1'b1;
          i_nxt = 1'b1;
          pending_nxt = 8'd0;
        end else if (take_entry) begin
          sv_we = 1'b1;
          mode_nxt = ent_mode;
          t_nxt = 1'b0;
          i_nxt = 1'b1;
          f_nxt = f_r || (pick == EXC_FIQ);
          pending_nxt = pending_r & ~(8'd1 << pick);
          reg_we = 1'b1;
          reg_slot = lr.slot;
          reg_data = phys_r[SLOT_PC] + PC_OFFSET;
          pc_we = 1'b1;
        end
      end
      KIND_WRITE: reg_we = acc.ok;
      default: ;
    endcase
  end

  // saved status as seen after this transaction
  always_comb begin
    saved_rd = saved_r[mode_nxt];
    if (sv_we && ent_mode == mode_nxt) begin
      saved_rd = sv_data;
    end
    if (clear_all) begin
      saved_rd = 4'd0;
    end
  end

  always_comb begin
    out_nxt.taken = take_any ? ({1'b0, pick} + 4'd1) : 4'd0;
    out_nxt.read_data = (item_r.kind == KIND_READ && acc.ok) ? phys_r[acc.slot] : 32'd0;
    out_nxt.access_error = (item_r.kind == KIND_READ || item_r.kind == KIND_WRITE) && !acc.ok;
    out_nxt.cpsr_mode = {1'b1, mode_nxt};
    out_nxt.saved_mode = saved_rd;
    out_nxt.irq_disabled = i_nxt;
    out_nxt.fiq_disabled = f_nxt;
    out_nxt.thumb_state = t_nxt;
    out_nxt.pending = pending_nxt;
    out_nxt.flush = take_reset || take_entry;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
    if (cmd.exec) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SVC;
      t_r <= 1'b0;
      f_r <= 1'b1;
      i_r <= 1'b1;
      pending_r <= 8'd0;
      for (int k = 0; k < NumPhys; k++) begin
        phys_r[k] <= 32'd0;
      end
      for (int k = 0; k < NumSaved; k++) begin
        saved_r[k] <= 4'd0;
      end
    end else if (cmd.exec) begin
      mode_r <= mode_nxt;
      t_r <= t_nxt;
      f_r <= f_nxt;
      i_r <= i_nxt;
      pending_r <= pending_nxt;
      if (clear_all) begin
        for (int k = 0; k < NumPhys; k++) begin
          phys_r[k] <= 32'd0;
        end
        for (int k = 0; k < NumSaved; k++) begin
          saved_r[k] <= 4'd0;
        end
      end else begin
        if (reg_we) begin
          phys_r[reg_slot] <= reg_data;
        end
        if (pc_we) begin
          phys_r[SLOT_PC] <= pc_data;
        end
        if (sv_we) begin
          saved_r[ent_mode] <= sv_data;
        end
      end
    end
  end

  assign out_item = out_r;

endmodule

/* dv/banked_register_file_exception_entry_core_tb.sv */
// ----------------------------------------------------------------------------
// banked_register_file_exception_entry_core_tb
// Self-checking testbench for the banked register file with exception entry.
// A directed table covers reset state, unbanked modes, spare kinds, every
// exception and the banked registers. Random traffic follows under random
// idling on both sides. Each result is checked against the row's typed
// expectation or a cycle-free model of the banks, status and pending bits.
// ----------------------------------------------------------------------------
module banked_register_file_exception_entry_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import brf_pkg::*;

  localparam int NUM_DIRECTED = 26;
  localparam int NUM_RANDOM = 2000;
  localparam int LIMIT_CYCLES = 600000;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int MAX_PRINTS = 60;

  localparam logic [2:0] KIND_SPARE5 = 3'd5;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;
  localparam logic [3:0] MODE_HOLE_LO = 4'h4;
  localparam logic [3:0] MODE_HOLE_HI = 4'hE;
  localparam logic [3:0] REG_PC = 4'd15;
  localparam logic [3:0] TAKEN_NONE = 4'd0;
  localparam logic [3:0] TAKEN_UNPRED = 4'd1;
  localparam logic [3:0] TAKEN_RESET = 4'd2;

  // status word layout
  localparam int STAT_T = 5;
  localparam int STAT_F = 6;
  localparam int STAT_I = 7;
  localparam logic [11:0] STATUS_AT_RESET = 12'h0D3;
  localparam logic [4:0] MODE_AT_RESET = 5'h13;
  localparam logic [46:0] UNTYPED = '0;

  typedef struct packed {
    in_item_t    stim;
    logic        typed;
    logic [3:0]  taken;
    logic [31:0] rdata;
    logic        aerr;
    logic [7:0]  pend;
    logic        flush;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  // model of the block state
  logic [31:0] model_regs [NumPhys];
  logic [11:0] model_status;
  logic [11:0] model_saved [NumSaved];
  logic [7:0]  model_pend;

  out_item_t expected_q [$];
  int        mismatches = 0;
  int        items_sent = 0;
  bit        squeeze_req = 1'b0;

  banked_register_file_exception_entry_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  function automatic void clear_model();
    for (int i = 0; i < NumPhys; i++) model_regs[i] = '0;
    for (int i = 0; i < NumSaved; i++) model_saved[i] = '0;
    model_status = STATUS_AT_RESET;
    model_pend = '0;
  endfunction

  // physical register behind (mode, register), -1 for an undefined mode
  function automatic int phys_index(logic [3:0] mode, logic [3:0] r);
    int sp_slot;
    sp_slot = 0;
    case (mode)
      MODE_USR, MODE_SYS: return int'(r);
      MODE_FIQ: begin
        if (r >= REG_R8 && r <= REG_R12) return int'(SLOT_FIQ_R8) + int'(r) - int'(REG_R8);
        sp_slot = int'(SLOT_FIQ_SP);
      end
      MODE_IRQ: sp_slot = int'(SLOT_IRQ_SP);
      MODE_SVC: sp_slot = int'(SLOT_SVC_SP);
      MODE_ABT: sp_slot = int'(SLOT_ABT_SP);
      MODE_UND: sp_slot = int'(SLOT_UND_SP);
      default: return -1;
    endcase
    if (r == REG_SP) return sp_slot;
    if (r == REG_LR) return sp_slot + 1;
    return int'(r);
  endfunction

  function automatic out_item_t next_result(in_item_t it);
    out_item_t   r;
    int          slot;
    int          b;
    logic [2:0]  hit;
    logic [3:0]  tgt;
    logic [31:0] vec;
    r = '0;
    case (it.kind)
      KIND_RAISE: model_pend = model_pend | it.exc_mask;
      KIND_CLEAR: model_pend = model_pend & ~it.exc_mask;
      KIND_HANDLE: begin
        if (model_pend[EXC_UNPRED]) begin
          r.taken = TAKEN_UNPRED;
        end else if (model_pend[EXC_RESET]) begin
          clear_model();
          r.taken = TAKEN_RESET;
          r.flush = 1'b1;
        end else if (model_pend != '0) begin
          // downward scan leaves the lowest set bit, the highest priority
          hit = EXC_FIQ;
          for (b = int'(EXC_FIQ); b >= int'(EXC_UNDEF); b--) begin
            if (model_pend[b]) hit = 3'(b);
          end
          case (hit)
            EXC_UNDEF: begin tgt = MODE_UND; vec = 32'h0000_0004; end
            EXC_SWI:   begin tgt = MODE_SVC; vec = 32'h0000_0008; end
            EXC_PABT:  begin tgt = MODE_ABT; vec = 32'h0000_000C; end
            EXC_DABT:  begin tgt = MODE_ABT; vec = 32'h0000_0010; end
            EXC_IRQ:   begin tgt = MODE_IRQ; vec = 32'h0000_0018; end
            default:   begin tgt = MODE_FIQ; vec = 32'h0000_001C; end
          endcase
          model_saved[tgt] = model_status;
          model_status[4:0] = {1'b1, tgt};
          model_status[STAT_T] = 1'b0;
          model_status[STAT_I] = 1'b1;
          if (hit == EXC_FIQ) model_status[STAT_F] = 1'b1;
          model_regs[phys_index(tgt, REG_LR)] = model_regs[SLOT_PC] + PC_OFFSET;
          model_regs[SLOT_PC] = vec;
          model_pend[hit] = 1'b0;
          r.taken = {1'b0, hit} + 4'd1;
          r.flush = 1'b1;
        end
      end
      KIND_READ, KIND_WRITE: begin
        slot = phys_index(it.bank_mode, it.reg_index);
        if (slot < 0) begin
          r.access_error = 1'b1;
        end else if (it.kind == KIND_READ) begin
          r.read_data = model_regs[slot];
        end else begin
          model_regs[slot] = it.write_data;
        end
      end
      default: ;
    endcase
    r.cpsr_mode = model_status[4:0];
    r.saved_mode = model_saved[model_status[3:0]][3:0];
    r.irq_disabled = model_status[STAT_I];
    r.fiq_disabled = model_status[STAT_F];
    r.thumb_state = model_status[STAT_T];
    r.pending = model_pend;
    return r;
  endfunction

  function automatic dir_row_t directed_row(int i);
    dir_row_t r;
    case (i)
      // reset state, unbanked modes and spare kinds
      0: r = {KIND_READ, 8'h00, MODE_USR, 4'd0, 32'h0, 1'b1, TAKEN_NONE, 32'h0, 1'b0, 8'h00, 1'b0};
      1: r = {KIND_READ, 8'h00, MODE_HOLE_LO, REG_SP, 32'h0,
              1'b1, TAKEN_NONE, 32'h0, 1'b1, 8'h00, 1'b0};
      2: r = {KIND_WRITE, 8'h00, MODE_HOLE_HI, REG_PC, 32'hFFFF_FFFF,
              1'b1, TAKEN_NONE, 32'h0, 1'b1, 8'h00, 1'b0};
      3: r = {KIND_HANDLE, 8'h00, MODE_USR, 4'd0, 32'h0,
              1'b1, TAKEN_NONE, 32'h0, 1'b0, 8'h00, 1'b0};
      4: r = {KIND_SPARE5, 8'h00, MODE_USR, 4'd0, 32'h0,
              1'b1, TAKEN_NONE, 32'h0, 1'b0, 8'h00, 1'b0};
      5: r = {KIND_SPARE7, 8'hFF, MODE_SYS, REG_PC, 32'hFFFF_FFFF,
              1'b1, TAKEN_NONE, 32'h0, 1'b0, 8'h00, 1'b0};
      // unpredictable blocks, then reset wipes everything
      6: r = {KIND_RAISE, 8'hFF, MODE_USR, 4'd0, 32'h0,
              1'b1, TAKEN_NONE, 32'h0, 1'b0, 8'hFF, 1'b0};
      7: r = {KIND_HANDLE, 8'h00, MODE_USR, 4'd0, 32'h0,
              1'b1, TAKEN_UNPRED, 32'h0, 1'b0, 8'hFF, 1'b0};
      8: r = {KIND_CLEAR, 8'h01, MODE_USR, 4'd0, 32'h0,
              1'b1, TAKEN_NONE, 32'h0, 1'b0, 8'hFE, 1'b0};
      9: r = {KIND_HANDLE, 8'h00, MODE_USR, 4'd0, 32'h0,
              1'b1, TAKEN_RESET, 32'h0, 1'b0, 8'h00, 1'b1};
      // pc near the top so lr = pc + 8 wraps
      10: r = {KIND_WRITE, 8'h00, MODE_USR, REG_PC, 32'hFFFF_FFF8, UNTYPED};
      11: r = {KIND_WRITE, 8'h00, MODE_FIQ, REG_R8, 32'hFFFF_FFFF, UNTYPED};
      12: r = {KIND_WRITE, 8'h00, MODE_FIQ, REG_R12, 32'hA5A5_A5A5, UNTYPED};
      13: r = {KIND_WRITE, 8'h00, MODE_SVC, REG_SP, 32'h1234_5678, UNTYPED};
      14: r = {KIND_RAISE, 8'hFC, MODE_USR, 4'd0, 32'h0, UNTYPED};
      15, 16, 17, 18, 19, 20: r = {KIND_HANDLE, 8'h00, MODE_USR, 4'd0, 32'h0, UNTYPED};
      21: r = {KIND_READ, 8'h00, MODE_UND, REG_LR, 32'h0, UNTYPED};
      22: r = {KIND_READ, 8'h00, MODE_FIQ, REG_R8, 32'h0, UNTYPED};
      23: r = {KIND_READ, 8'h00, MODE_USR, REG_PC, 32'h0, UNTYPED};
      24: r = {KIND_READ, 8'h00, MODE_ABT, REG_LR, 32'h0, UNTYPED};
      default: r = {KIND_READ, 8'h00, MODE_FIQ, REG_LR, 32'h0, UNTYPED};
    endcase
    return r;
  endfunction

  function automatic logic [3:0] random_mode();
    if ($urandom_range(0, 99) < 15) return 4'($urandom);
    case ($urandom_range(0, 6))
      0: return MODE_USR;
      1: return MODE_FIQ;
      2: return MODE_IRQ;
      3: return MODE_SVC;
      4: return MODE_ABT;
      5: return MODE_UND;
      default: return MODE_SYS;
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       sel;
    sel = $urandom_range(0, 99);
    it.exc_mask = 8'($urandom);
    it.bank_mode = random_mode();
    it.reg_index = 4'($urandom);
    it.write_data = $urandom;
    if (sel < 14) begin
      it.kind = KIND_RAISE;
      // mostly real exceptions; unpredictable and reset only now and then
      if ($urandom_range(0, 19) != 0) begin
        it.exc_mask = (8'd1 << $urandom_range(2, 7)) | (8'd1 << $urandom_range(2, 7));
      end
    end else if (sel < 22) begin
      it.kind = KIND_CLEAR;
    end else if (sel < 42) begin
      it.kind = KIND_HANDLE;
    end else if (sel < 68) begin
      it.kind = KIND_READ;
    end else if (sel < 96) begin
      it.kind = KIND_WRITE;
    end else begin
      it.kind = 3'($urandom_range(int'(KIND_SPARE5), int'(KIND_SPARE7)));
    end
    return it;
  endfunction

  // offer one transaction, log its prediction once accepted, then sometimes idle a while
  task automatic transfer(in_item_t it, bit use_typed, out_item_t typed_want);
    out_item_t want;
    int        gap;
    int        r;
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = next_result(it);
    if (use_typed) want = typed_want;
    expected_q.push_back(want);
    items_sent++;
    r = $urandom_range(0, 99);
    if ((items_sent % 300) < 40 || r < 50) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 24);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic flag_mismatch(string msg);
    if (mismatches < MAX_PRINTS) $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_q.size() == 0) begin
      flag_mismatch("result with no transaction outstanding");
      return;
    end
    want = expected_q.pop_front();
    if (got.taken !== want.taken)
      flag_mismatch($sformatf("taken %0d, expected %0d", got.taken, want.taken));
    if (got.read_data !== want.read_data)
      flag_mismatch($sformatf("read_data %h, expected %h", got.read_data, want.read_data));
    if (got.access_error !== want.access_error)
      flag_mismatch($sformatf("access_error %b, expected %b",
                              got.access_error, want.access_error));
    if (got.cpsr_mode !== want.cpsr_mode)
      flag_mismatch($sformatf("cpsr_mode %h, expected %h", got.cpsr_mode, want.cpsr_mode));
    if (got.saved_mode !== want.saved_mode)
      flag_mismatch($sformatf("saved_mode %h, expected %h", got.saved_mode, want.saved_mode));
    if (got.irq_disabled !== want.irq_disabled)
      flag_mismatch($sformatf("irq_disabled %b, expected %b",
                              got.irq_disabled, want.irq_disabled));
    if (got.fiq_disabled !== want.fiq_disabled)
      flag_mismatch($sformatf("fiq_disabled %b, expected %b",
                              got.fiq_disabled, want.fiq_disabled));
    if (got.thumb_state !== want.thumb_state)
      flag_mismatch($sformatf("thumb_state %b, expected %b", got.thumb_state, want.thumb_state));
    if (got.pending !== want.pending)
      flag_mismatch($sformatf("pending %h, expected %h", got.pending, want.pending));
    if (got.flush !== want.flush)
      flag_mismatch($sformatf("flush %b, expected %b", got.flush, want.flush));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_item);
  end

  // result side: random stall and run stretches, one long squeeze on request
  initial begin : result_side
    int hold;
    int run;
    int r;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold = SQUEEZE_CYCLES;
      end else if (r < 40) begin
        hold = 0;
      end else if (r < 88) begin
        hold = $urandom_range(1, 3);
      end else begin
        hold = $urandom_range(10, 40);
      end
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (run) @(posedge clk);
    end
  end

  initial begin : stimulus
    dir_row_t  row;
    out_item_t typed_want;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    clear_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = directed_row(i);
      // typed rows all sit in the reset status
      typed_want = '0;
      typed_want.taken = row.taken;
      typed_want.read_data = row.rdata;
      typed_want.access_error = row.aerr;
      typed_want.cpsr_mode = MODE_AT_RESET;
      typed_want.irq_disabled = 1'b1;
      typed_want.fiq_disabled = 1'b1;
      typed_want.pending = row.pend;
      typed_want.flush = row.flush;
      transfer(row.stim, row.typed, typed_want);
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 300) squeeze_req = 1'b1;
      transfer(random_item(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (expected_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/brf_pkg.sv
src/brf_ctrl.sv
src/brf_dp.sv
src/banked_register_file_exception_entry_core.sv
dv/banked_register_file_exception_entry_core_tb.sv
